[rtl/core/dcsma_pkg.sv]
// Package for the dual-channel scaled moving average block.
// Holds widths, scale factors and reciprocal constants for the constant dividers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dcsma_pkg;

  localparam int RAW_W  = 12;
  localparam int AVG0_W = 13;
  localparam int AVG1_W = 12;
  localparam int DIG_W  = 4;

  localparam int WINDOW = 20;
  localparam int WIN_LG = $clog2(WINDOW);
  localparam int SLOT_W = (WIN_LG < 1) ? 1 : WIN_LG;

  // Scale factors.
  localparam int CH0_NUM = 5052;
  localparam int CH0_DEN = 3274;
  localparam int CH1_NUM = 999;
  localparam int CH1_DEN = 1850;

  // Products of a raw sample and its numerator.
  localparam int P0_W = RAW_W + $clog2(CH0_NUM);
  localparam int P1_W = RAW_W + $clog2(CH1_NUM);

  // Division by a constant d for dividends below 2^N: multiply by
  // ceil(2^(N+l)/d) with l = clog2(d) and keep the bits above N+l. This is
  // exact for every dividend in range, so no correction step is needed.
  localparam int CH0_SH = P0_W + $clog2(CH0_DEN);
  localparam int R0_W   = P0_W + 1;
  localparam logic [R0_W-1:0] CH0_RECIP =
    R0_W'(((64'd1 << CH0_SH) + 64'(CH0_DEN) - 64'd1) / 64'(CH0_DEN));

  localparam int CH1_SH = P1_W + $clog2(CH1_DEN);
  localparam int R1_W   = P1_W + 1;
  localparam logic [R1_W-1:0] CH1_RECIP =
    R1_W'(((64'd1 << CH1_SH) + 64'(CH1_DEN) - 64'd1) / 64'(CH1_DEN));

  // Running sums hold up to WINDOW scaled values.
  localparam int SUM0_W = AVG0_W + WIN_LG;
  localparam int SUM1_W = AVG1_W + WIN_LG;

  localparam int WS0_SH = SUM0_W + WIN_LG;
  localparam int WR0_W  = SUM0_W + 1;
  localparam logic [WR0_W-1:0] WIN0_RECIP =
    WR0_W'(((64'd1 << WS0_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam int WS1_SH = SUM1_W + WIN_LG;
  localparam int WR1_W  = SUM1_W + 1;
  localparam logic [WR1_W-1:0] WIN1_RECIP =
    WR1_W'(((64'd1 << WS1_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  // Decimal split of a value below 2^AVG0_W.
  localparam int Q1000_W = 4;
  localparam int Q100_W  = 7;
  localparam int Q10_W   = 10;

  localparam int D1000_SH = AVG0_W + 10;
  localparam int D1000_RW = AVG0_W + 1;
  localparam logic [D1000_RW-1:0] D1000_RECIP =
    D1000_RW'(((64'd1 << D1000_SH) + 64'd999) / 64'd1000);

  localparam int D100_SH = AVG0_W + 7;
  localparam int D100_RW = AVG0_W + 1;
  localparam logic [D100_RW-1:0] D100_RECIP =
    D100_RW'(((64'd1 << D100_SH) + 64'd99) / 64'd100);

  localparam int D10_SH = AVG0_W + 4;
  localparam int D10_RW = AVG0_W + 1;
  localparam logic [D10_RW-1:0] D10_RECIP =
    D10_RW'(((64'd1 << D10_SH) + 64'd9) / 64'd10);

  typedef struct packed {
    logic load_q;   // quotient stage takes a new average
    logic load_d;   // digit stage takes the quotients
  } digit_ctl_t;

  typedef struct packed {
    logic [DIG_W-1:0] thousands;
    logic [DIG_W-1:0] hundreds;
    logic [DIG_W-1:0] tens;
    logic [DIG_W-1:0] units;
  } digits_t;

endpackage

`default_nettype wire

[rtl/core/dcsma_ifs.sv]
// Handshake interfaces for the sample and result channels.
// Depends on dcsma_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dcsma_in_if;
  logic                         valid;
  logic                         ready;
  logic [dcsma_pkg::RAW_W-1:0]  ch0_raw;
  logic [dcsma_pkg::RAW_W-1:0]  ch1_raw;

  modport source (output valid, ch0_raw, ch1_raw, input ready);
  modport sink   (input valid, ch0_raw, ch1_raw, output ready);
endinterface

interface dcsma_out_if;
  logic                         valid;
  logic                         ready;
  logic [dcsma_pkg::AVG0_W-1:0] ch0_average;
  logic [dcsma_pkg::AVG1_W-1:0] ch1_average;
  logic [dcsma_pkg::DIG_W-1:0]  ch0_thousands;
  logic [dcsma_pkg::DIG_W-1:0]  ch0_hundreds;
  logic [dcsma_pkg::DIG_W-1:0]  ch0_tens;
  logic [dcsma_pkg::DIG_W-1:0]  ch0_units;
  logic [dcsma_pkg::DIG_W-1:0]  ch1_thousands;
  logic [dcsma_pkg::DIG_W-1:0]  ch1_hundreds;
  logic [dcsma_pkg::DIG_W-1:0]  ch1_tens;
  logic [dcsma_pkg::DIG_W-1:0]  ch1_units;

  modport source (output valid, ch0_average, ch1_average,
                  ch0_thousands, ch0_hundreds, ch0_tens, ch0_units,
                  ch1_thousands, ch1_hundreds, ch1_tens, ch1_units,
                  input ready);
  modport sink   (input valid, ch0_average, ch1_average,
                  ch0_thousands, ch0_hundreds, ch0_tens, ch0_units,
                  ch1_thousands, ch1_hundreds, ch1_tens, ch1_units,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/dcsma_digits.sv]
// Two-stage decimal splitter for one channel average.
// Depends on dcsma_pkg; control comes from the pipeline in the top level.
`timescale 1ns / 1ps
`default_nettype none

module dcsma_digits (
  input  wire                          clk,
  input  wire dcsma_pkg::digit_ctl_t   ctl,
  input  wire [dcsma_pkg::AVG0_W-1:0]  avg_in,
  output logic [dcsma_pkg::AVG0_W-1:0] avg_out,
  output dcsma_pkg::digits_t           digits
);

  localparam int M1000_W = dcsma_pkg::AVG0_W + dcsma_pkg::D1000_RW;
  localparam int M100_W  = dcsma_pkg::AVG0_W + dcsma_pkg::D100_RW;
  localparam int M10_W   = dcsma_pkg::AVG0_W + dcsma_pkg::D10_RW;

  logic [M1000_W-1:0] m1000;
  logic [M100_W-1:0]  m100;
  logic [M10_W-1:0]   m10;

  logic [dcsma_pkg::AVG0_W-1:0]  avg_q;
  logic [dcsma_pkg::Q1000_W-1:0] q1000;
  logic [dcsma_pkg::Q100_W-1:0]  q100;
  logic [dcsma_pkg::Q10_W-1:0]   q10;

  logic [dcsma_pkg::Q100_W-1:0]  hund_full;
  logic [dcsma_pkg::Q10_W-1:0]   tens_full;
  logic [dcsma_pkg::AVG0_W-1:0]  units_full;

  assign m1000 = M1000_W'(avg_in) * M1000_W'(dcsma_pkg::D1000_RECIP);
  assign m100  = M100_W'(avg_in) * M100_W'(dcsma_pkg::D100_RECIP);
  assign m10   = M10_W'(avg_in) * M10_W'(dcsma_pkg::D10_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.load_q) begin
      avg_q <= avg_in;
      q1000 <= m1000[dcsma_pkg::D1000_SH +: dcsma_pkg::Q1000_W];
      q100  <= m100[dcsma_pkg::D100_SH +: dcsma_pkg::Q100_W];
      q10   <= m10[dcsma_pkg::D10_SH +: dcsma_pkg::Q10_W];
    end
  end

  // Each digit below the thousands is a quotient less ten times the next coarser quotient.
  assign hund_full  = q100 - dcsma_pkg::Q100_W'(q1000 * 7'd10);
  assign tens_full  = q10 - dcsma_pkg::Q10_W'(q100 * 10'd10);
  assign units_full = avg_q - dcsma_pkg::AVG0_W'(q10 * 13'd10);

  always_ff @(posedge clk) begin
    if (ctl.load_d) begin
      avg_out          <= avg_q;
      digits.thousands <= q1000;
      digits.hundreds  <= hund_full[dcsma_pkg::DIG_W-1:0];
      digits.tens      <= tens_full[dcsma_pkg::DIG_W-1:0];
      digits.units     <= units_full[dcsma_pkg::DIG_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/dual_channel_scaled_moving_average_top.sv]
// Items pass the input, product, scale, sum, average and digit registers.
// Throughput: one item per cycle; each stage holds when the next is full,
// and only the running-sum stage carries state from one item to the next.
// Reset clears the pipeline valid bits, both rings, both sums and the slot
// counter, so the first WINDOW items average against zeros.
// Top level: scaling, ring and running sums, averaging; uses dcsma_pkg,
// dcsma_ifs and dcsma_digits.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_scaled_moving_average_top (
  input  wire          clk,
  input  wire          rst,
  dcsma_in_if.sink     sample_in,
  dcsma_out_if.source  result_out
);

  localparam int PM0_W = dcsma_pkg::P0_W + dcsma_pkg::R0_W;
  localparam int PM1_W = dcsma_pkg::P1_W + dcsma_pkg::R1_W;
  localparam int AM0_W = dcsma_pkg::SUM0_W + dcsma_pkg::WR0_W;
  localparam int AM1_W = dcsma_pkg::SUM1_W + dcsma_pkg::WR1_W;

  // Stage valid bits and the ready chain.
  logic v1, v2, v3, v4, v5, v6, v7;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  assign rdy7 = !v7 || result_out.ready;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign sample_in.ready = rdy1;

  logic load1, load2, load3, load4, load5;
  dcsma_pkg::digit_ctl_t dctl;

  assign load1       = sample_in.valid && rdy1;
  assign load2       = v1 && rdy2;
  assign load3       = v2 && rdy3;
  assign load4       = v3 && rdy4;
  assign load5       = v4 && rdy5;
  assign dctl.load_q = v5 && rdy6;
  assign dctl.load_d = v6 && rdy7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy1) v1 <= sample_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  // Stage 1: input register.
  logic [dcsma_pkg::RAW_W-1:0] raw0, raw1;

  always_ff @(posedge clk) begin
    if (load1) begin
      raw0 <= sample_in.ch0_raw;
      raw1 <= sample_in.ch1_raw;
    end
  end

  // Stage 2: multiply by the numerators.
  logic [dcsma_pkg::P0_W-1:0] prod0;
  logic [dcsma_pkg::P1_W-1:0] prod1;

  always_ff @(posedge clk) begin
    if (load2) begin
      prod0 <= dcsma_pkg::P0_W'(raw0) * dcsma_pkg::P0_W'(dcsma_pkg::CH0_NUM);
      prod1 <= dcsma_pkg::P1_W'(raw1) * dcsma_pkg::P1_W'(dcsma_pkg::CH1_NUM);
    end
  end

  // Stage 3: divide by the denominators through exact reciprocals.
  logic [PM0_W-1:0] quot0_full;
  logic [PM1_W-1:0] quot1_full;
  logic [dcsma_pkg::AVG0_W-1:0] scaled0;
  logic [dcsma_pkg::AVG1_W-1:0] scaled1;

  assign quot0_full = PM0_W'(prod0) * PM0_W'(dcsma_pkg::CH0_RECIP);
  assign quot1_full = PM1_W'(prod1) * PM1_W'(dcsma_pkg::CH1_RECIP);

  always_ff @(posedge clk) begin
    if (load3) begin
      scaled0 <= quot0_full[dcsma_pkg::CH0_SH +: dcsma_pkg::AVG0_W];
      scaled1 <= quot1_full[dcsma_pkg::CH1_SH +: dcsma_pkg::AVG1_W];
    end
  end

  // Stage 4: ring write and running-sum update. The sums are the stage
  // registers, and apart from reset they only move when an item enters this stage.
  logic [dcsma_pkg::AVG0_W-1:0] ring0 [dcsma_pkg::WINDOW];
  logic [dcsma_pkg::AVG1_W-1:0] ring1 [dcsma_pkg::WINDOW];
  logic [dcsma_pkg::SUM0_W-1:0] sum0, sum0_next;
  logic [dcsma_pkg::SUM1_W-1:0] sum1, sum1_next;
  logic [dcsma_pkg::SLOT_W-1:0] slot, slot_next;

  assign sum0_next = sum0 + dcsma_pkg::SUM0_W'(scaled0)
                   - dcsma_pkg::SUM0_W'(ring0[slot]);
  assign sum1_next = sum1 + dcsma_pkg::SUM1_W'(scaled1)
                   - dcsma_pkg::SUM1_W'(ring1[slot]);
  assign slot_next = (slot == dcsma_pkg::SLOT_W'(dcsma_pkg::WINDOW - 1))
                   ? '0 : slot + dcsma_pkg::SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dcsma_pkg::WINDOW; i++) begin
        ring0[i] <= '0;
        ring1[i] <= '0;
      end
      sum0 <= '0;
      sum1 <= '0;
      slot <= '0;
    end else if (load4) begin
      ring0[slot] <= scaled0;
      ring1[slot] <= scaled1;
      sum0        <= sum0_next;
      sum1        <= sum1_next;
      slot        <= slot_next;
    end
  end

  // Stage 5: divide the sums by the window length.
  logic [AM0_W-1:0] avg0_full;
  logic [AM1_W-1:0] avg1_full;
  logic [dcsma_pkg::AVG0_W-1:0] avg0;
  logic [dcsma_pkg::AVG1_W-1:0] avg1;

  assign avg0_full = AM0_W'(sum0) * AM0_W'(dcsma_pkg::WIN0_RECIP);
  assign avg1_full = AM1_W'(sum1) * AM1_W'(dcsma_pkg::WIN1_RECIP);

  always_ff @(posedge clk) begin
    if (load5) begin
      avg0 <= avg0_full[dcsma_pkg::WS0_SH +: dcsma_pkg::AVG0_W];
      avg1 <= avg1_full[dcsma_pkg::WS1_SH +: dcsma_pkg::AVG1_W];
    end
  end

  // Stages 6 and 7: decimal split and the output register.
  logic [dcsma_pkg::AVG0_W-1:0] avg0_out, avg1_out;
  dcsma_pkg::digits_t           dig0, dig1;

  dcsma_digits u_digits0 (
    .clk     (clk),
    .ctl     (dctl),
    .avg_in  (avg0),
    .avg_out (avg0_out),
    .digits  (dig0)
  );

  dcsma_digits u_digits1 (
    .clk     (clk),
    .ctl     (dctl),
    .avg_in  (dcsma_pkg::AVG0_W'(avg1)),
    .avg_out (avg1_out),
    .digits  (dig1)
  );

  assign result_out.valid         = v7;
  assign result_out.ch0_average   = avg0_out;
  assign result_out.ch1_average   = avg1_out[dcsma_pkg::AVG1_W-1:0];
  assign result_out.ch0_thousands = dig0.thousands;
  assign result_out.ch0_hundreds  = dig0.hundreds;
  assign result_out.ch0_tens      = dig0.tens;
  assign result_out.ch0_units     = dig0.units;
  assign result_out.ch1_thousands = dig1.thousands;
  assign result_out.ch1_hundreds  = dig1.hundreds;
  assign result_out.ch1_tens      = dig1.tens;
  assign result_out.ch1_units     = dig1.units;

endmodule

`default_nettype wire

[tb/window_average_checker.sv]
// Checker for the dual-channel scaled moving average block.
// Watches both channels, predicts every result item and compares it field by field.
// Depends on dcsma_pkg and the interfaces in dcsma_ifs.
`timescale 1ns / 1ps

module window_average_checker
  import dcsma_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dcsma_in_if  samples,
  dcsma_out_if results,
  output int   mismatch_count,
  output int   averages_pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [AVG0_W-1:0] avg0;
    logic [AVG1_W-1:0] avg1;
    digits_t           dig0;
    digits_t           dig1;
  } averages_t;

  logic [AVG0_W-1:0] window0 [WINDOW];
  logic [AVG1_W-1:0] window1 [WINDOW];
  int unsigned       total0;
  int unsigned       total1;
  int unsigned       next_slot;
  averages_t         expected_averages [$];

  initial begin
    mismatch_count   = 0;
    averages_pending = 0;
  end

  function automatic digits_t decimal_digits(int unsigned v);
    digits_t d;
    d.thousands = DIG_W'(v / 1000);
    d.hundreds  = DIG_W'((v / 100) % 10);
    d.tens      = DIG_W'((v / 10) % 10);
    d.units     = DIG_W'(v % 10);
    return d;
  endfunction

  // Scales one sample pair, slides it into both windows and returns the new averages.
  function automatic averages_t slide_window(logic [RAW_W-1:0] raw0, logic [RAW_W-1:0] raw1);
    int unsigned scaled0;
    int unsigned scaled1;
    int unsigned mean0;
    int unsigned mean1;
    averages_t   r;
    scaled0 = (int'(raw0) * 5052) / 3274;
    scaled1 = (int'(raw1) * 999) / 1850;
    total0  = total0 + scaled0 - window0[next_slot];
    total1  = total1 + scaled1 - window1[next_slot];
    window0[next_slot] = AVG0_W'(scaled0);
    window1[next_slot] = AVG1_W'(scaled1);
    next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
    mean0  = total0 / WINDOW;
    mean1  = total1 / WINDOW;
    r.avg0 = AVG0_W'(mean0);
    r.avg1 = AVG1_W'(mean1);
    r.dig0 = decimal_digits(mean0);
    r.dig1 = decimal_digits(mean1);
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatch_count < REPORT_LIMIT)
        $display("%t %s: expected %0d, got %0d", $realtime, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    averages_t want;
    if (rst) begin
      foreach (window0[i]) window0[i] = '0;
      foreach (window1[i]) window1[i] = '0;
      total0    = 0;
      total1    = 0;
      next_slot = 0;
      expected_averages.delete();
    end else begin
      // Retire a result before queuing a new sample, so an item can never meet
      // the expectation it produced in the same cycle.
      if (results.valid && results.ready) begin
        if (expected_averages.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%t result item with no sample outstanding: avg0 %0d avg1 %0d",
                     $realtime, results.ch0_average, results.ch1_average);
          mismatch_count++;
        end else begin
          want = expected_averages.pop_front();
          check_field("ch0_average",   want.avg0,           results.ch0_average);
          check_field("ch1_average",   want.avg1,           results.ch1_average);
          check_field("ch0_thousands", want.dig0.thousands, results.ch0_thousands);
          check_field("ch0_hundreds",  want.dig0.hundreds,  results.ch0_hundreds);
          check_field("ch0_tens",      want.dig0.tens,      results.ch0_tens);
          check_field("ch0_units",     want.dig0.units,     results.ch0_units);
          check_field("ch1_thousands", want.dig1.thousands, results.ch1_thousands);
          check_field("ch1_hundreds",  want.dig1.hundreds,  results.ch1_hundreds);
          check_field("ch1_tens",      want.dig1.tens,      results.ch1_tens);
          check_field("ch1_units",     want.dig1.units,     results.ch1_units);
        end
      end
      if (samples.valid && samples.ready)
        expected_averages.push_back(slide_window(samples.ch0_raw, samples.ch1_raw));
    end
    averages_pending <= expected_averages.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the testbench for dual_channel_scaled_moving_average_top.
// Drives sample pairs with random gaps, stalls the result side and gives the verdict;
// depends on dcsma_pkg, dcsma_ifs, the block itself and window_average_checker.
`timescale 1ns / 1ps

module tb_top;
  import dcsma_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    SEG_UNIFORM,
    SEG_STEADY,
    SEG_RAILS,
    SEG_LOW,
    SEG_RAMP
  } segment_kind_e;

  logic clk;
  logic rst;
  logic no_idle;
  int   mismatch_count;
  int   averages_pending;
  int   idle_cycles = 0;

  dcsma_in_if  sample_ch ();
  dcsma_out_if result_ch ();

  dual_channel_scaled_moving_average_top dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_ch),
    .result_out (result_ch)
  );

  window_average_checker avg_check (
    .clk              (clk),
    .rst              (rst),
    .samples          (sample_ch),
    .results          (result_ch),
    .mismatch_count   (mismatch_count),
    .averages_pending (averages_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_pair(logic [RAW_W-1:0] raw0, logic [RAW_W-1:0] raw1);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.ch0_raw <= raw0;
    sample_ch.ch1_raw <= raw1;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    @(negedge clk);
  endtask

  // Result side: stalls a random number of cycles before taking each item.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
      @(negedge clk);
    end
  end

  initial begin
    int               sent;
    int               seg_len;
    segment_kind_e    seg;
    logic [RAW_W-1:0] a;
    logic [RAW_W-1:0] b;
    logic [RAW_W-1:0] hold0;
    logic [RAW_W-1:0] hold1;
    sample_ch.valid   = 1'b0;
    sample_ch.ch0_raw = '0;
    sample_ch.ch1_raw = '0;
    no_idle = 1'b0;
    rst     = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zeros, a full window at full scale to reach the largest
    // averages, then each channel at a rail and alternating bit patterns.
    send_pair('0, '0);
    repeat (WINDOW) send_pair('1, '1);
    send_pair('1, '0);
    send_pair('0, '1);
    send_pair(12'hAAA, 12'h555);
    send_pair(12'h555, 12'hAAA);
    send_pair(12'd1, 12'd1);

    // Random segments; steady runs settle the window on a known level so the
    // averages sweep their whole range, not just the middle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(1, 45);
      seg     = segment_kind_e'($urandom_range(0, 4));
      no_idle = ($urandom_range(0, 3) == 0);
      hold0   = $urandom_range(0, 4095);
      hold1   = $urandom_range(0, 4095);
      for (int k = 0; k < seg_len; k++) begin
        case (seg)
          SEG_STEADY: begin
            a = hold0;
            b = hold1;
          end
          SEG_RAILS: begin
            a = $urandom_range(0, 1) ? '1 : '0;
            b = $urandom_range(0, 1) ? '1 : '0;
          end
          SEG_LOW: begin
            a = $urandom_range(0, 15);
            b = $urandom_range(0, 15);
          end
          SEG_RAMP: begin
            a = hold0 + RAW_W'(k * 97);
            b = hold1 - RAW_W'(k * 61);
          end
          default: begin
            a = $urandom_range(0, 4095);
            b = $urandom_range(0, 4095);
          end
        endcase
        send_pair(a, b);
        sent++;
      end
    end
    sample_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (averages_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && averages_pending == 0) begin
      $display("dual_channel_scaled_moving_average_top: match");
    end else begin
      $display("dual_channel_scaled_moving_average_top: mismatch");
    end
    $finish;
  end

  // Ends a run that has stopped moving on both channels.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("dual_channel_scaled_moving_average_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
